@@ hw/rtl/htmc_pkg.sv @@
// Package for the heading turn mode controller.
// Holds mode codes, fixed-point angle constants, the CORDIC arctangent table
// and the structs passed between the top level and the CORDIC unit.
package htmc_pkg;

  // Number of CORDIC vectoring iterations, capped by the table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ITER_W = $clog2(ATAN_LEN);

  // Q2.13 angles
  localparam int ANG_PI = 25736;
  localparam int ANG_TWO_PI = 51472;

  // CORDIC datapath: offsets scaled by 2^20, angle accumulator in Q.24
  localparam int DIFF_W = 17;
  localparam int XY_W = 40;
  localparam int Z_W = 28;
  localparam int XY_SCALE = 20;
  localparam int ATAN_W = 24;
  localparam int PI_Q24 = 52707179;
  localparam int ROUND_SHIFT = 11;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_ACCEL   = 2'd1,
    MODE_MOVING  = 2'd2,
    MODE_TURNING = 2'd3
  } mode_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cordic_cmd_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] angle;
  } bearing_t;

  // atan(2^-i) in Q.24
  function automatic logic [ATAN_W-1:0] atan_q24(input logic [ITER_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:    r = 24'd13176795;
      5'd1:    r = 24'd7778716;
      5'd2:    r = 24'd4110060;
      5'd3:    r = 24'd2086331;
      5'd4:    r = 24'd1047214;
      5'd5:    r = 24'd524117;
      5'd6:    r = 24'd262123;
      5'd7:    r = 24'd131069;
      5'd8:    r = 24'd65536;
      5'd9:    r = 24'd32768;
      5'd10:   r = 24'd16384;
      5'd11:   r = 24'd8192;
      5'd12:   r = 24'd4096;
      5'd13:   r = 24'd2048;
      5'd14:   r = 24'd1024;
      5'd15:   r = 24'd512;
      5'd16:   r = 24'd256;
      5'd17:   r = 24'd128;
      5'd18:   r = 24'd64;
      5'd19:   r = 24'd32;
      5'd20:   r = 24'd16;
      5'd21:   r = 24'd8;
      5'd22:   r = 24'd4;
      5'd23:   r = 24'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/htmc_cordic.sv @@
// Iterative CORDIC vectoring unit: bearing of (dx, dy) in Q2.13 radians.
// One shift-add iteration per cycle, then rounding and wrap. Uses htmc_pkg.
module htmc_cordic import htmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cordic_cmd_t cmd,
  output bearing_t    res
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROUND} cstate_t;

  localparam logic signed [Z_W-1:0] PiZ = Z_W'(PI_Q24);
  localparam logic signed [Z_W-1:0] RoundHalf = Z_W'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [17:0] Pi18 = 18'(ANG_PI);
  localparam logic signed [17:0] TwoPi18 = 18'(ANG_TWO_PI);

  cstate_t                  state;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [Z_W-1:0]    z;
  logic signed [Z_W-1:0]    base;
  logic                     zero;
  logic [ITER_W-1:0]        iter;

  logic                     neg;
  logic signed [DIFF_W:0]   dx_m;
  logic signed [DIFF_W:0]   dy_m;
  logic signed [XY_W-1:0]   xs;
  logic signed [XY_W-1:0]   ys;
  logic signed [Z_W-1:0]    step_ang;
  logic signed [Z_W-1:0]    z_sum;
  logic signed [17:0]       ang;
  logic signed [17:0]       ang_w;

  always_comb begin
    neg = cmd.dx < 0;
    dx_m = neg ? -(DIFF_W+1)'(cmd.dx) : (DIFF_W+1)'(cmd.dx);
    dy_m = neg ? -(DIFF_W+1)'(cmd.dy) : (DIFF_W+1)'(cmd.dy);
    xs = x >>> iter;
    ys = y >>> iter;
    step_ang = signed'({{(Z_W-ATAN_W){1'b0}}, atan_q24(iter)});
    z_sum = z + base + RoundHalf;
    ang = 18'(signed'(z_sum[Z_W-1:ROUND_SHIFT]));
    if (ang < -Pi18) begin
      ang_w = ang + TwoPi18;
    end else if (ang > Pi18) begin
      ang_w = ang - TwoPi18;
    end else begin
      ang_w = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      res.valid <= 1'b0;
      iter <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.start) begin
            res.valid <= 1'b0;
            zero <= (cmd.dx == 0) && (cmd.dy == 0);
            base <= neg ? ((cmd.dy >= 0) ? PiZ : -PiZ) : '0;
            x <= XY_W'(dx_m) <<< XY_SCALE;
            y <= XY_W'(dy_m) <<< XY_SCALE;
            z <= '0;
            iter <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + step_ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - step_ang;
          end
          iter <= iter + 1'b1;
          if (iter == ITER_W'(CORDIC_ITERS - 1)) begin
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          // a target on the vehicle has bearing zero
          res.angle <= zero ? '0 : ang_w[15:0];
          res.valid <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/heading_turn_mode_controller_top.sv @@
// Heading turn mode controller, top level: handshake, config registers,
// sequencer with one shared multiplier, mode/heading state and output register.
// Depends on htmc_pkg and htmc_cordic.

// From acceptance to result, the CORDIC unit takes a start step,
// CORDIC_STEPS (16) shift-add iterations and a rounding step, and the error
// and update steps follow it; the squared speed, squared attack speed and turn
// step share one multiplier during the CORDIC run.
// in_ready is high only while no item is in work; a finished result waits in
// the output register, so the next item can be taken while it is pending.
// Heading: Q2.13, reset 0. Mode: reset stopped. The user writes configuration
// via cfg_write/cfg_index/cfg_data only while idle, not enforced by the block.
module heading_turn_mode_controller_top import htmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] vehicle_x,
  input  logic signed [15:0] vehicle_y,
  input  logic signed [15:0] velocity_x,
  input  logic signed [15:0] velocity_y,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         mode,
  output logic signed [15:0] turn_command
);

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegRate = 2'd1;
  localparam logic [1:0] RegAttack = 2'd2;
  localparam logic signed [17:0] Pi18 = 18'(ANG_PI);
  localparam logic signed [17:0] TwoPi18 = 18'(ANG_TWO_PI);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_VX, S_SQ_VY, S_SQ_AT, S_RATE, S_MAG, S_WAIT, S_ERR, S_UPDATE
  } state_t;

  state_t              state;
  logic [14:0]         turn_threshold;
  logic [14:0]         angular_rate;
  logic [14:0]         attack_speed;
  mode_t               cur_mode;
  logic signed [15:0]  heading;
  logic signed [15:0]  vx;
  logic signed [15:0]  vy;
  logic [15:0]         dt;
  logic signed [33:0]  prod;
  logic [31:0]         speed_sq;
  logic [29:0]         attack_sq;
  logic [15:0]         mag;
  logic signed [15:0]  target;
  logic                too_far;
  logic                side_pos;
  mode_t               out_mode;

  cordic_cmd_t         ccmd;
  bearing_t            cres;

  logic                in_acc;
  logic                out_free;
  logic signed [16:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic [31:0]         rate_round;
  logic signed [17:0]  err;
  logic [17:0]         abs_err;
  logic [17:0]         fold_err;
  logic signed [17:0]  side;
  logic signed [17:0]  head_sum;
  logic signed [17:0]  head_w;
  logic signed [15:0]  rate_s;
  mode_t               mode_n;
  logic signed [15:0]  heading_n;
  logic signed [15:0]  cmd_n;

  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mode = out_mode;

  assign ccmd.start = in_acc;
  assign ccmd.dx = DIFF_W'(target_x) - DIFF_W'(vehicle_x);
  assign ccmd.dy = DIFF_W'(target_y) - DIFF_W'(vehicle_y);

  htmc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .cmd (ccmd),
    .res (cres)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_SQ_VX: begin
        mul_a = 17'(vx);
        mul_b = 17'(vx);
      end
      S_SQ_VY: begin
        mul_a = 17'(vy);
        mul_b = 17'(vy);
      end
      S_SQ_AT: begin
        mul_a = signed'({2'b0, attack_speed});
        mul_b = signed'({2'b0, attack_speed});
      end
      S_RATE: begin
        mul_a = signed'({2'b0, angular_rate});
        mul_b = signed'({1'b0, dt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rate_round = prod[31:0] + 32'd32768;

    // wrapped error between bearing and heading
    err = 18'(target) - 18'(heading);
    abs_err = (err < 0) ? 18'(-err) : 18'(err);
    fold_err = (abs_err > 18'(ANG_PI)) ? 18'(ANG_TWO_PI) - abs_err : abs_err;
    if (err < -Pi18) begin
      side = err + TwoPi18;
    end else if (err > Pi18) begin
      side = err - TwoPi18;
    end else begin
      side = err;
    end

    // heading integration toward the shorter side
    head_sum = side_pos ? 18'(heading) + signed'({2'b0, mag})
                        : 18'(heading) - signed'({2'b0, mag});
    if (head_sum < -Pi18) begin
      head_w = head_sum + TwoPi18;
    end else if (head_sum > Pi18) begin
      head_w = head_sum - TwoPi18;
    end else begin
      head_w = head_sum;
    end

    rate_s = signed'({1'b0, angular_rate});
    mode_n = cur_mode;
    heading_n = heading;
    cmd_n = '0;
    if (too_far || (cur_mode == MODE_TURNING)) begin
      mode_n = MODE_TURNING;
      cmd_n = side_pos ? rate_s : -rate_s;
      heading_n = head_w[15:0];
      if (!too_far) begin
        heading_n = target;
        mode_n = MODE_ACCEL;
        cmd_n = target;
      end
    end else begin
      unique case (cur_mode)
        MODE_STOPPED: mode_n = MODE_ACCEL;
        MODE_ACCEL: begin
          if (speed_sq >= {2'b0, attack_sq}) begin
            mode_n = MODE_MOVING;
          end
        end
        default: mode_n = cur_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      turn_threshold <= 15'd1430;
      angular_rate <= 15'd8192;
      attack_speed <= 15'd2560;
      cur_mode <= MODE_STOPPED;
      heading <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          RegThreshold: turn_threshold <= cfg_data;
          RegRate:      angular_rate <= cfg_data;
          RegAttack:    attack_speed <= cfg_data;
          default:      ;
        endcase
      end

      if ((state == S_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      prod <= mul_a * mul_b;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            vx <= velocity_x;
            vy <= velocity_y;
            dt <= time_step;
            state <= S_SQ_VX;
          end
        end
        S_SQ_VX: state <= S_SQ_VY;
        S_SQ_VY: begin
          speed_sq <= prod[31:0];
          state <= S_SQ_AT;
        end
        S_SQ_AT: begin
          speed_sq <= speed_sq + prod[31:0];
          state <= S_RATE;
        end
        S_RATE: begin
          attack_sq <= prod[29:0];
          state <= S_MAG;
        end
        S_MAG: begin
          mag <= rate_round[31:16];
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (cres.valid) begin
            target <= cres.angle;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          too_far <= fold_err > {3'b0, turn_threshold};
          side_pos <= side > 0;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          // commit only when the output register is free
          if (out_free) begin
            cur_mode <= mode_n;
            heading <= heading_n;
            out_mode <= mode_n;
            turn_command <= cmd_n;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/htmc_checker.sv @@
// Port-level checker for the heading turn mode controller, bound to the top.
// Depends on htmc_pkg for the mode codes.
module htmc_checker import htmc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         mode,
  input logic signed [15:0] turn_command
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(turn_command))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // every item leaves the stopped mode
  a_never_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode != 2'(MODE_STOPPED))
    else $error("result reports stopped mode");

  // moving mode never carries a turn command
  a_moving_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == 2'(MODE_MOVING)) |-> turn_command == 16'sd0)
    else $error("turn command in moving mode");

endmodule

bind heading_turn_mode_controller_top htmc_checker u_htmc_checker (.*);

@@ tb/sv/heading_turn_mode_controller_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for heading_turn_mode_controller_top: a directed table, then random
// target/vehicle tracks under several register settings, each result checked in order.
// Depends on htmc_pkg (mode_t) and the controller RTL.
module heading_turn_mode_controller_top_test;
  import htmc_pkg::*;

  localparam logic [1:0] CFG_TURN_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_ANGULAR_RATE   = 2'd1;
  localparam logic [1:0] CFG_ATTACK_SPEED   = 2'd2;

  localparam int     PI_Q13       = 25736;
  localparam int     TWO_PI_Q13   = 51472;
  localparam longint PI_Q24_ANGLE = 52707179;
  localparam int     ATAN_STEPS   = 16;
  localparam longint ATAN_Q24 [ATAN_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  localparam int LONG_HOLD_AT     = 250;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct {
    logic signed [15:0] tgt_x;
    logic signed [15:0] tgt_y;
    logic signed [15:0] veh_x;
    logic signed [15:0] veh_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0]        dt;
    bit                 typed;
    mode_t              mode;
    logic signed [15:0] cmd;
  } tick_row_t;

  typedef struct {
    mode_t              mode;
    logic signed [15:0] cmd;
  } tick_result_t;

  typedef struct {
    int thr;
    int rate;
    int atk;
    int rx_pct;
    int tx_pct;
    bit rand_cfg;
  } phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] target_x = '0;
  logic signed [15:0] target_y = '0;
  logic signed [15:0] vehicle_x = '0;
  logic signed [15:0] vehicle_y = '0;
  logic signed [15:0] velocity_x = '0;
  logic signed [15:0] velocity_y = '0;
  logic [15:0]        time_step = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         mode;
  logic signed [15:0] turn_command;

  // typed expectation travels with the payload of a directed row
  logic               row_typed = 1'b0;
  mode_t              row_mode = MODE_STOPPED;
  logic signed [15:0] row_cmd = '0;

  logic [14:0]  thr_cfg = 15'd1430;
  logic [14:0]  rate_cfg = 15'd8192;
  logic [14:0]  attack_cfg = 15'd2560;
  mode_t        mode_state = MODE_STOPPED;
  int           heading_state = 0;
  tick_result_t pending_results [$];

  int err_count = 0;
  int items_in = 0;
  int rx_stall_pct = 20;
  int tx_gap_pct = 20;
  int rx_wait = 0;
  bit long_hold_done = 1'b0;
  int quiet_cycles = 0;

  tick_row_t directed_rows [] = '{
    // zero offset, stopped with small error
    '{0, 0, 0, 0, 0, 0, 0, 1, MODE_ACCEL, 0},
    // speed just below and exactly at attack speed
    '{0, 0, 0, 0, 2559, 0, 0, 1, MODE_ACCEL, 0},
    '{0, 0, 0, 0, 2560, 0, 0, 1, MODE_MOVING, 0},
    '{0, 0, 0, 0, -32768, -32768, 0, 1, MODE_MOVING, 0},
    // target straight up, no time passes
    '{0, 100, 0, 0, 0, 0, 0, 1, MODE_TURNING, 8192},
    '{0, 100, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{0, 100, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{0, 100, 0, 0, 0, 0, 30000, 0, MODE_STOPPED, 0},
    '{0, 100, 0, 0, 0, 0, 1000, 0, MODE_STOPPED, 0},
    '{0, 100, 0, 0, 32767, 32767, 500, 0, MODE_STOPPED, 0},
    // negative x axis
    '{-100, 0, 0, 0, 0, 0, 4000, 0, MODE_STOPPED, 0},
    '{-100, 0, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{-32768, 0, 32767, 0, 0, 0, 0, 0, MODE_STOPPED, 0},
    '{32767, 32767, -32768, -32768, 0, 0, 12345, 0, MODE_STOPPED, 0},
    '{-32768, -32768, 32767, 32767, 0, 0, 54321, 0, MODE_STOPPED, 0},
    '{0, -1, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{-1, -1, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{-1, 0, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{5, 0, 0, 0, -32768, 32767, 0, 0, MODE_STOPPED, 0},
    '{5, 0, 0, 0, 0, 0, 65535, 0, MODE_STOPPED, 0},
    '{5, 0, 0, 0, 0, 0, 8192, 0, MODE_STOPPED, 0},
    '{5, 0, 0, 0, 3000, -3000, 2048, 0, MODE_STOPPED, 0}
  };

  // threshold at pi means turning is never forced
  phase_t phase_plan [6] = '{
    '{0, 32767, 0, 20, 20, 0},
    '{25736, 0, 32767, 30, 10, 0},
    '{1430, 8192, 2560, 0, 0, 0},
    '{0, 0, 0, 25, 25, 1},
    '{700, 4000, 1000, 10, 40, 0},
    '{0, 0, 0, 50, 50, 1}
  };

  heading_turn_mode_controller_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_x     (target_x),
    .target_y     (target_y),
    .vehicle_x    (vehicle_x),
    .vehicle_y    (vehicle_y),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .time_step    (time_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mode         (mode),
    .turn_command (turn_command)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int wrap_pi(input int a);
    if (a < -PI_Q13) a += TWO_PI_Q13;
    if (a > PI_Q13) a -= TWO_PI_Q13;
    return a;
  endfunction

  // vectoring atan2 on offsets scaled by 2^20, angle kept in Q.24
  function automatic int cordic_bearing(input int dx, input int dy);
    longint x, y, z, base, xs, ys;
    int i;
    z = 0;
    base = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      base = (dy >= 0) ? PI_Q24_ANGLE : -PI_Q24_ANGLE;
      dx = -dx;
      dy = -dy;
    end
    x = longint'(dx) <<< 20;
    y = longint'(dy) <<< 20;
    for (i = 0; i < ATAN_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q24[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q24[i];
      end
    end
    return wrap_pi(int'((z + base + 1024) >>> 11));
  endfunction

  function automatic tick_result_t predict_tick(input tick_row_t t);
    int dx, dy, bearing, err, abs_err, side, cmd;
    longint step, speed_sq;
    bit too_far;
    tick_result_t r;
    dx = int'(t.tgt_x) - int'(t.veh_x);
    dy = int'(t.tgt_y) - int'(t.veh_y);
    bearing = cordic_bearing(dx, dy);
    err = bearing - heading_state;
    abs_err = (err < 0) ? -err : err;
    if (abs_err > PI_Q13) abs_err = TWO_PI_Q13 - abs_err;
    too_far = abs_err > int'(thr_cfg);
    cmd = 0;
    if (too_far) mode_state = MODE_TURNING;
    case (mode_state)
      MODE_TURNING: begin
        side = wrap_pi(err);
        step = (longint'(rate_cfg) * longint'(t.dt) + 32768) >>> 16;
        cmd = (side > 0) ? int'(rate_cfg) : -int'(rate_cfg);
        heading_state = wrap_pi((side > 0) ? heading_state + int'(step)
                                           : heading_state - int'(step));
        // turn done: heading snaps to the bearing, which is sent out
        if (!too_far) begin
          heading_state = bearing;
          mode_state = MODE_ACCEL;
          cmd = bearing;
        end
      end
      MODE_STOPPED: mode_state = MODE_ACCEL;
      MODE_ACCEL: begin
        speed_sq = longint'(t.vel_x) * longint'(t.vel_x) + longint'(t.vel_y) * longint'(t.vel_y);
        if (speed_sq >= longint'(attack_cfg) * longint'(attack_cfg)) mode_state = MODE_MOVING;
      end
      default: ;
    endcase
    r.mode = mode_state;
    r.cmd = cmd[15:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic offer_tick(input tick_row_t row);
    int gap;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    target_x   <= row.tgt_x;
    target_y   <= row.tgt_y;
    vehicle_x  <= row.veh_x;
    vehicle_y  <= row.veh_y;
    velocity_x <= row.vel_x;
    velocity_y <= row.vel_y;
    time_step  <= row.dt;
    row_typed  <= row.typed;
    row_mode   <= row.mode;
    row_cmd    <= row.cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [14:0] thr, input logic [14:0] rate,
                             input logic [14:0] atk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TURN_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_ANGULAR_RATE;
    cfg_data  <= rate;
    @(posedge clk);
    cfg_index <= CFG_ATTACK_SPEED;
    cfg_data  <= atk;
    @(posedge clk);
    cfg_write <= 1'b0;
    thr_cfg = thr;
    rate_cfg = rate;
    attack_cfg = atk;
  endtask

  // Mostly tracks: a fixed target, a vehicle creeping about, so the heading can
  // converge and the mode walk through accelerating and moving. Rest is noise.
  task automatic run_random(input int count);
    tick_row_t row;
    int n, len, k;
    bit noisy, near, fast;
    n = 0;
    row.typed = 1'b0;
    row.mode = MODE_STOPPED;
    row.cmd = '0;
    while (n < count) begin
      noisy = ($urandom_range(0, 4) == 0);
      near = ($urandom_range(0, 1) == 1);
      fast = ($urandom_range(0, 1) == 1);
      len = noisy ? 1 : $urandom_range(4, 24);
      row.tgt_x = 16'($urandom);
      row.tgt_y = 16'($urandom);
      row.veh_x = near ? 16'(row.tgt_x + ($urandom_range(0, 200) - 100)) : 16'($urandom);
      row.veh_y = near ? 16'(row.tgt_y + ($urandom_range(0, 200) - 100)) : 16'($urandom);
      for (k = 0; k < len && n < count; k++) begin
        if (noisy) begin
          row.vel_x = 16'($urandom);
          row.vel_y = 16'($urandom);
          row.dt = 16'($urandom);
        end else begin
          row.veh_x = 16'(row.veh_x + ($urandom_range(0, 6) - 3));
          row.veh_y = 16'(row.veh_y + ($urandom_range(0, 6) - 3));
          fast = fast || ($urandom_range(0, 7) == 0);
          row.vel_x = fast ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
          row.vel_y = fast ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
          row.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
        end
        offer_tick(row);
        n++;
      end
    end
  endtask

  // receiver: random stalls, plus one long hold so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (!long_hold_done && items_in >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      rx_wait <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_wait <= pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_row_t seen;
    tick_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.tgt_x = target_x;
        seen.tgt_y = target_y;
        seen.veh_x = vehicle_x;
        seen.veh_y = vehicle_y;
        seen.vel_x = velocity_x;
        seen.vel_y = velocity_y;
        seen.dt = time_step;
        seen.typed = 1'b0;
        seen.mode = MODE_STOPPED;
        seen.cmd = '0;
        want = predict_tick(seen);
        if (row_typed) begin
          want.mode = row_mode;
          want.cmd = row_cmd;
        end
        pending_results.push_back(want);
        items_in <= items_in + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending: mode %0d, turn_command %0d", mode, turn_command);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (mode !== want.mode) begin
            $error("mode mismatch: expected %0d, got %0d", want.mode, mode);
            err_count++;
          end
          if (turn_command !== want.cmd) begin
            $error("turn_command mismatch: expected %0d, got %0d", want.cmd, turn_command);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("heading_turn_mode_controller_top test failed");
      $finish;
    end
  end

  initial begin
    int i, p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < directed_rows.size(); i++) offer_tick(directed_rows[i]);
    drain_results();
    for (p = 0; p < 6; p++) begin
      repeat (4) @(posedge clk);
      if (phase_plan[p].rand_cfg)
        load_config(15'($urandom_range(0, PI_Q13)), 15'($urandom_range(0, 32767)),
                    15'($urandom_range(0, 32767)));
      else
        load_config(15'(phase_plan[p].thr), 15'(phase_plan[p].rate),
                    15'(phase_plan[p].atk));
      rx_stall_pct = phase_plan[p].rx_pct;
      tx_gap_pct = phase_plan[p].tx_pct;
      run_random(55);
      // sender holds until every result sent so far in this phase is back
      drain_results();
      run_random(60);
      drain_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("heading_turn_mode_controller_top test passed");
    end else begin
      $display("heading_turn_mode_controller_top test failed");
    end
    $finish;
  end

endmodule
